// ===== src/mse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg: shared types and constants for the MIPS subset execute block
// Opcode and function codes, decoded-op structure and sizes.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int DATA_WORDS = 1024;
  localparam int MEM_AW     = $clog2(DATA_WORDS);

  localparam logic [31:0] START_RST = 32'h0040_0000;
  localparam logic [31:0] STACK_RST = 32'd1023;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_STACK = 1'b1;

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;

  // function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  // ALU / class codes
  localparam logic [3:0] K_ADD  = 4'd0;
  localparam logic [3:0] K_SUB  = 4'd1;
  localparam logic [3:0] K_AND  = 4'd2;
  localparam logic [3:0] K_OR   = 4'd3;
  localparam logic [3:0] K_NOR  = 4'd4;
  localparam logic [3:0] K_SLT  = 4'd5;
  localparam logic [3:0] K_SLTU = 4'd6;
  localparam logic [3:0] K_SLL  = 4'd7;
  localparam logic [3:0] K_SRL  = 4'd8;
  localparam logic [3:0] K_LUI  = 4'd9;
  localparam logic [3:0] K_JR   = 4'd10;
  localparam logic [3:0] K_BR   = 4'd11;
  localparam logic [3:0] K_JMP  = 4'd12;
  localparam logic [3:0] K_LW   = 4'd13;
  localparam logic [3:0] K_SW   = 4'd14;
  localparam logic [3:0] K_UNK  = 4'd15;

  typedef struct packed {
    logic [3:0]  kind;
    logic        use_imm;   // second operand is the immediate
    logic        br_eq;     // beq (else bne)
    logic        link;      // jal
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  dst;
    logic [4:0]  sh;
    logic [31:0] imm;       // already extended
    logic [25:0] target;
  } dec_t;

endpackage

// ===== src/mse_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_decode: instruction classifier
// Pure decode of one instruction word into a dec_t record.
// ----------------------------------------------------------------------------
module mse_decode
  import mse_pkg::*;
(
  input  logic [31:0] instr,
  output dec_t        dec
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [31:0] simm;
  logic [31:0] zimm;

  assign op   = instr[31:26];
  assign fn   = instr[5:0];
  assign simm = {{16{instr[15]}}, instr[15:0]};
  assign zimm = {16'd0, instr[15:0]};

  // field split and class selection
  always_comb begin
    dec         = '0;
    dec.rs      = instr[25:21];
    dec.rt      = instr[20:16];
    dec.sh      = instr[10:6];
    dec.target  = instr[25:0];
    dec.imm     = simm;
    dec.dst     = instr[20:16];
    dec.use_imm = 1'b1;
    dec.kind    = K_UNK;
    unique case (op)
      OP_RTYPE: begin
        dec.use_imm = 1'b0;
        dec.dst     = instr[15:11];
        unique case (fn)
          FN_ADD, FN_ADDU: dec.kind = K_ADD;
          FN_SUB, FN_SUBU: dec.kind = K_SUB;
          FN_AND:          dec.kind = K_AND;
          FN_OR:           dec.kind = K_OR;
          FN_NOR:          dec.kind = K_NOR;
          FN_SLT:          dec.kind = K_SLT;
          FN_SLTU:         dec.kind = K_SLTU;
          FN_SLL:          dec.kind = K_SLL;
          FN_SRL:          dec.kind = K_SRL;
          FN_JR:           dec.kind = K_JR;
          default:         dec.kind = K_UNK;
        endcase
      end
      OP_ADDI, OP_ADDIU: dec.kind = K_ADD;
      OP_SLTI:           dec.kind = K_SLT;
      OP_SLTIU:          dec.kind = K_SLTU;
      OP_ANDI: begin
        dec.kind = K_AND;
        dec.imm  = zimm;
      end
      OP_ORI: begin
        dec.kind = K_OR;
        dec.imm  = zimm;
      end
      OP_LUI: begin
        dec.kind = K_LUI;
        dec.imm  = {instr[15:0], 16'd0};
      end
      OP_BEQ, OP_BNE: begin
        dec.kind    = K_BR;
        dec.use_imm = 1'b0;
        dec.br_eq   = (op == OP_BEQ);
      end
      OP_J, OP_JAL: begin
        dec.kind = K_JMP;
        dec.link = (op == OP_JAL);
        dec.dst  = 5'd31;
      end
      OP_LW: dec.kind = K_LW;
      OP_SW: dec.kind = K_SW;
      default: dec.kind = K_UNK;
    endcase
  end

endmodule

// ===== src/mse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_front: input stage and decoded-op queue
// Accepts instruction transactions, decodes them and holds them in a
// two-entry queue for the execute stage.
// ----------------------------------------------------------------------------
module mse_front
  import mse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  output logic        q_valid,
  input  logic        q_ready,
  output dec_t        q_dec
);

  dec_t       dec;
  dec_t       slot_r [2];
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  mse_decode u_dec (
    .instr (in_tdata),
    .dec   (dec)
  );

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_dec     = slot_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  // pointer and count update
  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== src/mse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_back: execute stage
// Register file, program counter, ALU, branch logic and data memory.
// Loads read the memory through a registered read port; the result
// register issues one transaction per cycle while out_tready allows it.
// ----------------------------------------------------------------------------
module mse_back
  import mse_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  dec_t          q_dec,
  input  logic          cfg_we,
  input  logic          cfg_addr,
  input  logic [31:0]   cfg_wdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [119:0]  out_tdata
);

  logic [31:0] rf_r [32];
  logic [31:0] mem_r [DATA_WORDS];
  logic [31:0] pc_r;
  logic [31:0] mem_q_r;

  // output register
  logic        ov_r;
  logic        o_load_r;      // write_value comes from mem_q_r
  logic [31:0] o_pc_r, o_next_r, o_val_r;
  logic        o_rw_r, o_mw_r, o_bt_r, o_unk_r;
  logic [4:0]  o_dst_r;
  logic [9:0]  o_idx_r;

  logic        fire;
  logic [31:0] a, b, opb, pc4, res, sum, next;
  logic        wr, mw, taken, unk, ld;
  logic [4:0]  dst;
  logic [MEM_AW-1:0] midx;
  logic [31:0] wval;

  function automatic logic kind_mem(input logic [3:0] k);
    kind_mem = (k == K_LW) || (k == K_SW);
  endfunction

  assign q_ready = !ov_r || out_tready;
  assign fire    = q_valid && q_ready;

  // operand read with forwarding of a pending load result
  always_comb begin
    a = rf_r[q_dec.rs];
    b = rf_r[q_dec.rt];
    if (ov_r && o_load_r && o_rw_r && o_dst_r == q_dec.rs) a = mem_q_r;
    if (ov_r && o_load_r && o_rw_r && o_dst_r == q_dec.rt) b = mem_q_r;
    if (q_dec.rs == 5'd0) a = '0;
    if (q_dec.rt == 5'd0) b = '0;
  end

  assign opb = q_dec.use_imm ? q_dec.imm : b;
  assign pc4 = pc_r + 32'd4;
  assign sum = a + q_dec.imm;
  assign midx = sum[MEM_AW-1:0];

  // execute
  always_comb begin
    res   = '0;
    wr    = 1'b1;
    mw    = 1'b0;
    taken = 1'b0;
    unk   = 1'b0;
    ld    = 1'b0;
    next  = pc4;
    unique case (q_dec.kind)
      K_ADD:  res = a + opb;
      K_SUB:  res = a - opb;
      K_AND:  res = a & opb;
      K_OR:   res = a | opb;
      K_NOR:  res = ~(a | opb);
      K_SLT:  res = {31'd0, $signed(a) < $signed(opb)};
      K_SLTU: res = {31'd0, a < opb};
      K_SLL:  res = b << q_dec.sh;
      K_SRL:  res = b >> q_dec.sh;
      K_LUI:  res = q_dec.imm;
      K_JR: begin
        wr = 1'b0; taken = 1'b1; next = a;
      end
      K_BR: begin
        wr = 1'b0;
        if ((a == b) == q_dec.br_eq) begin
          taken = 1'b1;
          next  = pc4 + {q_dec.imm[29:0], 2'b00};
        end
      end
      K_JMP: begin
        taken = 1'b1;
        next  = {pc4[31:28], q_dec.target, 2'b00};
        wr    = q_dec.link;
        res   = pc4;
      end
      K_LW: ld = 1'b1;
      K_SW: begin
        wr = 1'b0; mw = 1'b1; res = b;
      end
      default: begin
        wr = 1'b0; unk = 1'b1;
      end
    endcase
    dst = q_dec.dst;
    // no register write: report none; a store keeps its stored word
    if (!(wr && dst != 5'd0)) begin
      wr  = 1'b0;
      dst = '0;
      ld  = 1'b0;
      if (!mw) res = '0;
    end
  end

  // reported write value: load data is fetched next cycle
  assign wval = o_load_r ? mem_q_r : o_val_r;

  // program counter and register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= START_RST;
      for (int i = 0; i < 32; i++) rf_r[i] <= (i == 29) ? STACK_RST : 32'd0;
    end else begin
      if (cfg_we && cfg_addr == CFG_START) pc_r <= cfg_wdata;
      else if (fire) pc_r <= next;
      if (cfg_we && cfg_addr == CFG_STACK) rf_r[29] <= cfg_wdata;
      else if (fire && wr && !ld) rf_r[dst] <= res;
      if (ov_r && o_load_r && o_rw_r && !(fire && wr && !ld && dst == o_dst_r))
        rf_r[o_dst_r] <= mem_q_r;
    end
  end

  // data memory: registered read
  always_ff @(posedge clk) begin
    if (fire && mw) mem_r[midx] <= b;
    if (fire && ld) mem_q_r <= mem_r[midx];
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r     <= 1'b0;
      o_load_r <= 1'b0;
    end else if (q_ready) begin
      ov_r     <= q_valid;
      o_load_r <= fire && ld;
    end
  end

  // result register payload; the load value is copied in while the report waits
  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      o_pc_r   <= pc_r;
      o_next_r <= next;
      o_rw_r   <= wr;
      o_dst_r  <= dst;
      o_val_r  <= res;
      o_mw_r   <= mw;
      o_idx_r  <= (kind_mem(q_dec.kind)) ? 10'(midx) : 10'd0;
      o_bt_r   <= taken;
      o_unk_r  <= unk;
    end else if (ov_r && o_load_r) begin
      o_val_r  <= mem_q_r;
    end
  end

  assign out_tvalid = ov_r;
  // fields from bit 0: instr_address, next_address, reg_write, dest_reg,
  // write_value, mem_write, mem_index, branch_taken, unknown_op, zero fill
  assign out_tdata = {5'd0, o_unk_r, o_bt_r, o_idx_r, o_mw_r, wval,
                      o_dst_r, o_rw_r, o_next_r, o_pc_r};

endmodule

// ===== src/mips_subset_execute_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_execute_top: MIPS32 integer subset execute block
// Path: an accepted instruction waits in a queue slot, then executes into the
// result register. Throughput: one instruction per cycle while out_tready
// allows it, set by the single execute stage.
// Reset (rst_n, synchronous): PC = 0x00400000, registers zero, r29 = 1023,
// queues empty. Data memory is not cleared.
// ----------------------------------------------------------------------------
module mips_subset_execute_top
  import mse_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,    // instruction
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,   // instr_address, next_address, reg_write,
                                    // dest_reg, write_value, mem_write,
                                    // mem_index, branch_taken, unknown_op
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  logic q_valid, q_ready;
  dec_t q_dec;

  mse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_dec     (q_dec)
  );

  mse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_dec      (q_dec),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sim/tb_mips_subset_execute_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mips_subset_execute_top: self-checking bench for the MIPS subset execute
// Instruction words stream in and execution reports stream out. A scoreboard
// keeps its own register file, data memory and program counter, predicts the
// report of every accepted word, and compares reports field by field. A short
// directed program runs first. Random programs follow under several sender
// and receiver idling mixes, with configuration writes between phases.
// ----------------------------------------------------------------------------
module tb_mips_subset_execute_top;
  import mse_pkg::*;

  // One execution report
  typedef struct {
    logic [31:0] instr_addr;
    logic [31:0] next_addr;
    logic        reg_wr;
    logic [4:0]  dest;
    logic [31:0] wr_val;
    logic        mem_wr;
    logic [9:0]  mem_idx;
    logic        taken;
    logic        unknown;
  } exec_rpt_t;

  // Scoreboard: architectural state plus the queue of expected reports
  class exec_scoreboard;
    logic [31:0] regs [32];
    logic [31:0] dmem [DATA_WORDS];
    bit          written [DATA_WORDS];
    logic [31:0] pc;
    exec_rpt_t   expected_rpts [$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[29] = STACK_RST;
      pc = START_RST;
      foreach (written[i]) written[i] = 1'b0;
      errors = 0;
    endfunction

    function void write_cfg(logic idx, logic [31:0] val);
      if (idx == CFG_START) pc = val;
      else regs[29] = val;
    endfunction

    // Execute one word against the model state and queue its report
    function void note_instr(logic [31:0] w);
      exec_rpt_t   r;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sh;
      logic [31:0] a, b, imm, simm, pc4, ea;
      logic [9:0]  idx;
      logic        wr;
      op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
      sh = w[10:6]; fn = w[5:0];
      imm = {16'h0, w[15:0]};
      simm = {{16{w[15]}}, w[15:0]};
      a = regs[rs]; b = regs[rt];
      pc4 = pc + 32'd4;
      r = '{pc, pc4, 1'b0, 5'd0, 32'd0, 1'b0, 10'd0, 1'b0, 1'b0};
      wr = 1'b1;
      if (op == OP_RTYPE) begin
        r.dest = rd;
        case (fn)
          FN_ADD, FN_ADDU: r.wr_val = a + b;
          FN_SUB, FN_SUBU: r.wr_val = a - b;
          FN_AND:  r.wr_val = a & b;
          FN_OR:   r.wr_val = a | b;
          FN_NOR:  r.wr_val = ~(a | b);
          FN_SLT:  r.wr_val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          FN_SLTU: r.wr_val = (a < b) ? 32'd1 : 32'd0;
          FN_SLL:  r.wr_val = b << sh;
          FN_SRL:  r.wr_val = b >> sh;
          FN_JR: begin
            wr = 1'b0; r.next_addr = a; r.taken = 1'b1;
          end
          default: begin
            wr = 1'b0; r.unknown = 1'b1;
          end
        endcase
      end else begin
        r.dest = rt;
        case (op)
          OP_ADDI, OP_ADDIU: r.wr_val = a + simm;
          OP_ANDI: r.wr_val = a & imm;
          OP_ORI:  r.wr_val = a | imm;
          OP_SLTI: r.wr_val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
          OP_SLTIU: r.wr_val = (a < simm) ? 32'd1 : 32'd0;
          OP_LUI:  r.wr_val = imm << 16;
          OP_BEQ, OP_BNE: begin
            wr = 1'b0;
            if ((a == b) == (op == OP_BEQ)) begin
              r.taken = 1'b1;
              r.next_addr = pc4 + (simm << 2);
            end
          end
          OP_LW: begin
            ea = a + simm;
            idx = ea[9:0];
            r.mem_idx = idx;
            r.wr_val = dmem[idx];
          end
          OP_SW: begin
            ea = a + simm;
            idx = ea[9:0];
            wr = 1'b0;
            r.mem_idx = idx;
            r.mem_wr = 1'b1;
            r.wr_val = b;
            dmem[idx] = b;
            written[idx] = 1'b1;
          end
          OP_J, OP_JAL: begin
            r.taken = 1'b1;
            r.next_addr = {pc4[31:28], w[25:0], 2'b00};
            if (op == OP_JAL) begin
              r.dest = 5'd31; r.wr_val = pc4;
            end else wr = 1'b0;
          end
          default: begin
            wr = 1'b0; r.unknown = 1'b1;
          end
        endcase
      end
      // register zero absorbs writes; reports collapse to nothing written
      if (wr && r.dest != 5'd0) begin
        regs[r.dest] = r.wr_val;
        r.reg_wr = 1'b1;
      end else begin
        r.reg_wr = 1'b0;
        r.dest = 5'd0;
        if (!r.mem_wr) r.wr_val = 32'd0;
      end
      pc = r.next_addr;
      expected_rpts.push_back(r);
    endfunction

    function void check_rpt(logic [119:0] d);
      exec_rpt_t got, exp_r;
      got.instr_addr = d[31:0];
      got.next_addr  = d[63:32];
      got.reg_wr     = d[64];
      got.dest       = d[69:65];
      got.wr_val     = d[101:70];
      got.mem_wr     = d[102];
      got.mem_idx    = d[112:103];
      got.taken      = d[113];
      got.unknown    = d[114];
      if (expected_rpts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected report at pc %h", got.instr_addr);
        return;
      end
      exp_r = expected_rpts.pop_front();
      if (got.instr_addr !== exp_r.instr_addr || got.next_addr !== exp_r.next_addr ||
          got.reg_wr !== exp_r.reg_wr || got.dest !== exp_r.dest ||
          got.wr_val !== exp_r.wr_val || got.mem_wr !== exp_r.mem_wr ||
          got.mem_idx !== exp_r.mem_idx || got.taken !== exp_r.taken ||
          got.unknown !== exp_r.unknown) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: report mismatch");
          $display("  exp pc %h nxt %h rw %0d rd %0d val %h mw %0d idx %0d br %0d unk %0d",
                   exp_r.instr_addr, exp_r.next_addr, exp_r.reg_wr, exp_r.dest,
                   exp_r.wr_val, exp_r.mem_wr, exp_r.mem_idx, exp_r.taken,
                   exp_r.unknown);
          $display("  got pc %h nxt %h rw %0d rd %0d val %h mw %0d idx %0d br %0d unk %0d",
                   got.instr_addr, got.next_addr, got.reg_wr, got.dest, got.wr_val,
                   got.mem_wr, got.mem_idx, got.taken, got.unknown);
        end
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [119:0] out_tdata;
  logic         cfg_we = 0;
  logic         cfg_addr = CFG_START;
  logic [31:0]  cfg_wdata = '0;

  exec_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  int  hold_left = 0;

  mips_subset_execute_top dut (.*);

  always #10 clk = ~clk;

  // Watchdog
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off while input keeps coming
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = 300;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Report monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_rpt(out_tdata);
  end

  function automatic logic [31:0] rtype(logic [4:0] rs, rt, rd, sh, logic [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Random instruction; loads are steered onto words already stored
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    logic [5:0]  ops [14];
    logic [5:0]  fns [12];
    logic [15:0] imm;
    logic [9:0]  k;
    int          sel, n;
    ops = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU,
            OP_ANDI, OP_ORI, OP_LUI, OP_LW, OP_SW, OP_SW};
    fns = '{FN_SLL, FN_SRL, FN_JR, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND,
            FN_OR, FN_NOR, FN_SLT, FN_SLTU};
    w = $urandom();
    case ($urandom_range(3))
      0: imm = 16'h0000;
      1: imm = 16'hFFFF;
      2: imm = 16'h8000;
      default: imm = 16'($urandom());
    endcase
    sel = $urandom_range(99);
    if (sel < 40) w = rtype(w[25:21], w[20:16], w[15:11], w[10:6], fns[$urandom_range(11)]);
    else if (sel < 90) w = {ops[$urandom_range(13)], w[25:16],
                            ($urandom_range(1) ? imm : w[15:0])};
    // remaining words stay raw noise, mostly unsupported encodings
    if (w[31:26] == OP_LW) begin
      n = 0;
      foreach (sb.written[i]) if (sb.written[i]) n++;
      if (n == 0) w[31:26] = OP_SW;
      else begin
        do k = 10'($urandom()); while (!sb.written[k]);
        w[15:0] = {6'($urandom_range(63)), 10'(k - sb.regs[w[25:21]][9:0])};
      end
    end
    return w;
  endfunction

  task automatic send_instr(logic [31:0] w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    sb.note_instr(w);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_rpts.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    sb.write_cfg(idx, val);
  endtask

  task automatic set_cfg(logic [31:0] start_addr, logic [31:0] stack_val);
    write_cfg(CFG_START, start_addr);
    write_cfg(CFG_STACK, stack_val);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] directed [$];
    logic [31:0] starts [4];
    logic [31:0] stacks [4];
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed program: extremes, every operation, special cases
    set_cfg(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    directed = '{
      rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_SLL),        // nop
      itype(OP_LUI, 5'd0, 5'd1, 16'hFFFF),
      itype(OP_ORI, 5'd1, 5'd1, 16'hFFFF),          // r1 = all ones, zero-extended imm
      itype(OP_ADDI, 5'd0, 5'd2, 16'h0001),
      rtype(5'd1, 5'd2, 5'd3, 5'd0, FN_ADD),        // wraps
      rtype(5'd29, 5'd2, 5'd3, 5'd0, FN_ADDU),
      rtype(5'd0, 5'd2, 5'd4, 5'd0, FN_SUB),
      rtype(5'd0, 5'd1, 5'd4, 5'd0, FN_SUBU),
      rtype(5'd1, 5'd2, 5'd5, 5'd0, FN_AND),
      rtype(5'd1, 5'd2, 5'd5, 5'd0, FN_OR),
      rtype(5'd0, 5'd0, 5'd5, 5'd0, FN_NOR),
      rtype(5'd1, 5'd2, 5'd6, 5'd0, FN_SLT),
      rtype(5'd1, 5'd2, 5'd6, 5'd0, FN_SLTU),
      rtype(5'd0, 5'd1, 5'd7, 5'd31, FN_SLL),
      rtype(5'd0, 5'd1, 5'd7, 5'd31, FN_SRL),       // logical shift
      itype(OP_ADDI, 5'd1, 5'd0, 16'h7FFF),         // write to register zero
      itype(OP_ADDIU, 5'd0, 5'd8, 16'h8000),
      itype(OP_ANDI, 5'd1, 5'd9, 16'h8000),
      itype(OP_SLTI, 5'd1, 5'd10, 16'h0000),
      itype(OP_SLTIU, 5'd0, 5'd10, 16'hFFFF),
      itype(OP_SW, 5'd0, 5'd1, 16'h0000),
      itype(OP_SW, 5'd0, 5'd2, 16'hFFFF),           // index wraps to top word
      itype(OP_LW, 5'd0, 5'd11, 16'h0400),          // reads word 0
      itype(OP_BEQ, 5'd0, 5'd0, 16'hFFFF),
      itype(OP_BNE, 5'd1, 5'd0, 16'h7FFF),
      {OP_J, 26'h3FF_FFFF},
      {OP_JAL, 26'h000_0000},
      rtype(5'd31, 5'd0, 5'd0, 5'd0, FN_JR),
      32'hFC00_0000,                                // unsupported opcode
      rtype(5'd0, 5'd0, 5'd0, 5'd0, 6'h0C)          // syscall, reported as unknown
    };
    foreach (directed[i]) send_instr(directed[i]);
    drain();

    // Random phases under different idling mixes
    starts = '{32'h0000_0000, 32'hFFFF_FFFC, START_RST, 32'h8000_0000};
    stacks = '{32'h0000_0000, 32'hFFFF_FFFF, STACK_RST, 32'h7FFF_FFFF};
    for (int ph = 0; ph < 4; ph++) begin
      set_cfg(ph == 3 ? $urandom() : starts[ph], stacks[ph]);
      send_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 16 : 0;
      recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 16 : 0;
      for (int n = 0; n < 155; n++) begin
        if (ph == 0 && n == 40) hold_req = 1;
        send_instr(rand_instr());
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_rpts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== mips_subset_execute_top.f =====
src/mse_pkg.sv
src/mse_decode.sv
src/mse_front.sv
src/mse_back.sv
src/mips_subset_execute_top.sv
sim/tb_mips_subset_execute_top.sv
